[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the z-score anomaly core.
// Depends on nothing; the user scope must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SZAD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies another one in the following cycle.
`define SZAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/szad_pkg.sv]
// Package for the sliding-window z-score anomaly core: sizes, state types
// and the structs that pass between the lanes, the merge stage and the top.
// Depends on nothing.
package szad_pkg;

  localparam int NUM_FEATURES = 4;
  localparam int FEATURE_BITS = 16;
  localparam int WINDOW_DEPTH = 1024;
  localparam int PTR_BITS     = $clog2(WINDOW_DEPTH);
  localparam int COUNT_BITS   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_BITS     = FEATURE_BITS + PTR_BITS;
  localparam int SQ_BITS      = 2 * FEATURE_BITS + PTR_BITS;
  localparam int NX_BITS      = FEATURE_BITS + COUNT_BITS;
  localparam int DIFF_BITS    = SUM_BITS;
  localparam int NUM_BITS     = 2 * DIFF_BITS;
  localparam int DEN_BITS     = SQ_BITS + COUNT_BITS;
  localparam int TERM_BITS    = 33;
  localparam int D2_BITS      = TERM_BITS + $clog2(NUM_FEATURES) + 1;
  localparam int WORD_BITS    = NUM_FEATURES * FEATURE_BITS;
  localparam int OUT_BITS     = 16;
  localparam logic [OUT_BITS-1:0] THRESHOLD_RESET = 16'd768;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL1, L_MUL2, L_MUL3, L_CHECK, L_DIV, L_DONE
  } lane_state_t;

  typedef enum logic [2:0] {
    M_IDLE, M_CHECK, M_SQRT, M_PREP, M_DIV, M_DONE
  } merge_state_t;

  typedef enum logic [1:0] {
    T_IDLE, T_START, T_WAIT, T_HOLD
  } core_state_t;

  typedef struct packed {
    logic                  start;
    logic                  full;
    logic [COUNT_BITS-1:0] n;
  } lane_ctrl_t;

  typedef struct packed {
    logic                 done;
    logic [TERM_BITS-1:0] term;
  } lane_status_t;

  typedef struct packed {
    logic                done;
    logic                anomaly;
    logic [OUT_BITS-1:0] zdist;
    logic [OUT_BITS-1:0] score;
  } merge_result_t;

endpackage

[rtl/szad_lane.sv]
// One feature lane: keeps the running sum and sum of squares of its feature
// and works out the squared z-score term with a 32-step divider.
// Depends on szad_pkg.
module szad_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  szad_pkg::lane_ctrl_t             ctrl,
  input  logic [szad_pkg::FEATURE_BITS-1:0] x,
  input  logic [szad_pkg::FEATURE_BITS-1:0] old_x,
  output szad_pkg::lane_status_t           status
);
  import szad_pkg::*;

  lane_state_t state, state_next;
  logic [SUM_BITS-1:0]  s_sum;
  logic [SQ_BITS-1:0]   q_sum;
  logic [DEN_BITS-1:0]  nq;
  logic [NUM_BITS-1:0]  ss;
  logic [NX_BITS-1:0]   nx;
  logic [2*FEATURE_BITS-1:0] xsq, osq;
  logic [DIFF_BITS-1:0] diff;
  logic [DEN_BITS-1:0]  den;
  logic [NUM_BITS-1:0]  num;
  logic [DEN_BITS-1:0]  rem;
  logic [31:0]          low;
  logic [30:0]          quo;
  logic [4:0]           cnt;
  logic [TERM_BITS-1:0] term;
  logic [DEN_BITS:0]    trial;
  logic                 take;
  logic                 den_zero, capped, div_last, lane_done;

  assign trial    = {rem, low[31]};
  assign take     = trial >= {1'b0, den};
  assign den_zero = den == '0;
  assign capped   = {1'b0, num[NUM_BITS-1:16]} >= den;
  assign div_last = cnt == 5'd31;

  // Every lane runs the full divider so that all lanes finish together; a
  // skipped or capped term keeps the value set in the check step.
  always_comb begin
    state_next = state;
    case (state)
      L_IDLE:  if (ctrl.start) state_next = L_MUL1;
      L_MUL1:  state_next = L_MUL2;
      L_MUL2:  state_next = L_MUL3;
      L_MUL3:  state_next = L_CHECK;
      L_CHECK: state_next = L_DIV;
      L_DIV:   if (div_last) state_next = L_DONE;
      L_DONE:  state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_comb begin
    lane_done = 1'b0;
    case (state)
      L_DONE:  lane_done = 1'b1;
      default: lane_done = 1'b0;
    endcase
  end

  assign status.done = lane_done;
  assign status.term = term;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      s_sum <= '0;
      q_sum <= '0;
    end else begin
      state <= state_next;
      if (state == L_MUL2) begin
        // The old word only leaves the sums once the window is full.
        s_sum <= s_sum + SUM_BITS'(x) - (ctrl.full ? SUM_BITS'(old_x) : '0);
        q_sum <= q_sum + SQ_BITS'(xsq) - (ctrl.full ? SQ_BITS'(osq) : '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_MUL1: begin
        nq  <= DEN_BITS'(ctrl.n) * DEN_BITS'(q_sum);
        ss  <= NUM_BITS'(s_sum) * NUM_BITS'(s_sum);
        nx  <= NX_BITS'(ctrl.n) * NX_BITS'(x);
        xsq <= x * x;
        osq <= old_x * old_x;
      end
      L_MUL2: begin
        diff <= (nx >= NX_BITS'(s_sum)) ? DIFF_BITS'(nx - NX_BITS'(s_sum))
                                        : DIFF_BITS'(NX_BITS'(s_sum) - nx);
        den  <= (nq > DEN_BITS'(ss)) ? nq - DEN_BITS'(ss) : '0;
      end
      L_MUL3: num <= NUM_BITS'(diff) * NUM_BITS'(diff);
      L_CHECK: begin
        rem <= DEN_BITS'(num[NUM_BITS-1:16]);
        low <= {num[15:0], 16'b0};
        quo <= '0;
        cnt <= '0;
        if (den_zero) term <= '0;
        else if (capped) term <= {1'b1, 32'b0};
      end
      L_DIV: begin
        rem <= take ? DEN_BITS'(trial - {1'b0, den}) : DEN_BITS'(trial);
        low <= {low[30:0], 1'b0};
        quo <= {quo[29:0], take};
        cnt <= cnt + 5'd1;
        if (div_last && !den_zero && !capped) term <= {1'b0, quo, take};
      end
      default: ;
    endcase
  end

endmodule

[rtl/szad_merge.sv]
// Merge stage: adds the lane terms, takes the integer square root bit by
// bit and divides the distance by the threshold for the score.
// Depends on szad_pkg.
module szad_merge (
  input  logic                                          clk,
  input  logic                                          rst,
  input  szad_pkg::lane_status_t [szad_pkg::NUM_FEATURES-1:0] lanes,
  input  logic [szad_pkg::OUT_BITS-1:0]                 threshold,
  output szad_pkg::merge_result_t                       result
);
  import szad_pkg::*;

  merge_state_t state, state_next;
  logic [D2_BITS-1:0]  d2, d2_sum;
  logic [31:0]         v, res, bitv;
  logic [4:0]          cnt;
  logic [OUT_BITS-1:0] zdist, score, rmd;
  logic [23:0]         dd;
  logic [22:0]         quo;
  logic [OUT_BITS:0]   trial;
  logic [31:0]         rb;
  logic                take, all_done, big, sqrt_last, div_last, thr_zero, mdone;

  always_comb begin
    all_done = 1'b1;
    d2_sum   = '0;
    for (int i = 0; i < NUM_FEATURES; i++) begin
      all_done = all_done & lanes[i].done;
      d2_sum   = d2_sum + D2_BITS'(lanes[i].term);
    end
  end

  assign big       = d2[D2_BITS-1:32] != '0;
  assign rb        = res + bitv;
  assign sqrt_last = cnt == 5'd15;
  assign div_last  = cnt == 5'd23;
  assign thr_zero  = threshold == '0;
  assign trial     = {rmd, dd[23]};
  assign take      = trial >= {1'b0, threshold};

  always_comb begin
    state_next = state;
    case (state)
      M_IDLE:  if (all_done) state_next = M_CHECK;
      M_CHECK: state_next = big ? M_PREP : M_SQRT;
      M_SQRT:  if (sqrt_last) state_next = M_PREP;
      M_PREP:  state_next = thr_zero ? M_DONE : M_DIV;
      M_DIV:   if (div_last) state_next = M_DONE;
      M_DONE:  state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  always_comb begin
    mdone = 1'b0;
    case (state)
      M_DONE:  mdone = 1'b1;
      default: mdone = 1'b0;
    endcase
  end

  assign result.done    = mdone;
  assign result.anomaly = zdist > threshold;
  assign result.zdist   = zdist;
  assign result.score   = score;

  always_ff @(posedge clk) begin
    if (rst) state <= M_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: d2 <= d2_sum;
      M_CHECK: begin
        v    <= d2[31:0];
        res  <= '0;
        bitv <= 32'h4000_0000;
        cnt  <= '0;
        if (big) zdist <= '1;
      end
      M_SQRT: begin
        if (v >= rb) begin
          v   <= v - rb;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (sqrt_last) zdist <= (v >= rb) ? OUT_BITS'((res >> 1) + bitv)
                                          : OUT_BITS'(res >> 1);
      end
      M_PREP: begin
        dd  <= {zdist, 8'b0};
        rmd <= '0;
        quo <= '0;
        cnt <= '0;
        if (thr_zero) score <= (zdist != '0) ? '1 : '0;
      end
      M_DIV: begin
        rmd <= take ? OUT_BITS'(trial - {1'b0, threshold}) : OUT_BITS'(trial);
        dd  <= {dd[22:0], 1'b0};
        quo <= {quo[21:0], take};
        cnt <= cnt + 5'd1;
        if (div_last) score <= (quo[22:15] != '0) ? '1 : {quo[14:0], take};
      end
      default: ;
    endcase
  end

endmodule

[rtl/sliding_window_zscore_anomaly_core.sv]
// Top level of the sliding-window z-score anomaly core: window memory,
// occupancy and pointer, four feature lanes, merge stage and output word.
// Depends on szad_pkg, szad_lane and szad_merge.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   feature_0..feature_3
//   out      output     out_valid/out_stall flagged, distance,
//                                           score, samples_held
//   config   input      cfg_write           cfg_data (threshold)
//
// A word's result shows on the output in the same cycle in which the next
// word can be taken; no new word is taken before the result of the last one
// has been loaded into the output word. The lane setup steps, the 32-step
// lane divider, the 16-step square root and the 24-step score divider make up
// that work; a saturated distance skips the root and a zero threshold skips
// the score divider. The lanes run side by side.
// Reset is synchronous and clears the sums, count and pointer and returns the
// threshold to 3.0; the window memory needs no clearing since an old word
// read from a slot only enters the sums once the window is full.
// A stalled output word holds; the next input word is taken while it waits,
// and a finished result waits inside the core until the output is free.
module sliding_window_zscore_anomaly_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [szad_pkg::FEATURE_BITS-1:0]  feature_0,
  input  logic [szad_pkg::FEATURE_BITS-1:0]  feature_1,
  input  logic [szad_pkg::FEATURE_BITS-1:0]  feature_2,
  input  logic [szad_pkg::FEATURE_BITS-1:0]  feature_3,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               flagged,
  output logic [szad_pkg::OUT_BITS-1:0]      distance,
  output logic [szad_pkg::OUT_BITS-1:0]      score,
  output logic [szad_pkg::COUNT_BITS-1:0]    samples_held,
  input  logic                               cfg_write,
  input  logic [szad_pkg::OUT_BITS-1:0]      cfg_data
);
  import szad_pkg::*;

  core_state_t state, state_next;
  logic [OUT_BITS-1:0]   threshold;
  logic [WORD_BITS-1:0]  window_mem [WINDOW_DEPTH];
  logic [WORD_BITS-1:0]  x_word, old_word, in_word;
  logic [PTR_BITS-1:0]   wp;
  logic [COUNT_BITS-1:0] count;
  logic                  accept, full, out_free, load_out, start, finish;
  lane_ctrl_t            ctrl;
  lane_status_t [NUM_FEATURES-1:0] lane_status;
  merge_result_t         result;

  assign in_word  = {feature_3, feature_2, feature_1, feature_0};
  assign accept   = in_valid && !in_stall;
  assign full     = count == COUNT_BITS'(WINDOW_DEPTH);
  assign out_free = !out_valid || !out_stall;

  // Next state of the word sequencer.
  always_comb begin
    state_next = state;
    case (state)
      T_IDLE:  if (in_valid) state_next = T_START;
      T_START: state_next = T_WAIT;
      T_WAIT:  if (result.done) state_next = T_HOLD;
      T_HOLD:  if (out_free) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // Strobes of the sequencer.
  always_comb begin
    in_stall = 1'b1;
    start    = 1'b0;
    finish   = 1'b0;
    load_out = 1'b0;
    case (state)
      T_IDLE:  in_stall = 1'b0;
      T_START: start = 1'b1;
      T_WAIT:  finish = result.done;
      T_HOLD:  load_out = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  assign ctrl.start = start;
  assign ctrl.full  = full;
  assign ctrl.n     = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      threshold <= THRESHOLD_RESET;
      wp        <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) threshold <= cfg_data;
      // The sums move to the new window in the lanes; the occupancy and the
      // pointer follow once the score has been worked out.
      if (finish) begin
        wp <= wp + PTR_BITS'(1);
        if (!full) count <= count + COUNT_BITS'(1);
      end
      if (load_out)      out_valid <= 1'b1;
      else if (out_free) out_valid <= 1'b0;
    end
  end

  // The slot at the pointer is read before it is overwritten, so the oldest
  // word is at hand when the window is full.
  always_ff @(posedge clk) begin
    if (accept) begin
      old_word       <= window_mem[wp];
      window_mem[wp] <= in_word;
      x_word         <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      flagged      <= result.anomaly;
      distance     <= result.zdist;
      score        <= result.score;
      samples_held <= count;
    end
  end

  for (genvar i = 0; i < NUM_FEATURES; i++) begin : g_lane
    szad_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .x      (x_word[i*FEATURE_BITS +: FEATURE_BITS]),
      .old_x  (old_word[i*FEATURE_BITS +: FEATURE_BITS]),
      .status (lane_status[i])
    );
  end

  szad_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lanes     (lane_status),
    .threshold (threshold),
    .result    (result)
  );

endmodule

[rtl/szad_checker.sv]
// Port-level checks for the z-score anomaly core and the bind that attaches
// them. Depends on szad_pkg, assert_macros.svh and the top level.
`include "assert_macros.svh"

module szad_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            flagged,
  input logic [szad_pkg::OUT_BITS-1:0]   distance,
  input logic [szad_pkg::OUT_BITS-1:0]   score,
  input logic [szad_pkg::COUNT_BITS-1:0] samples_held
);
  import szad_pkg::*;

  `SZAD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output word dropped")
  `SZAD_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "second word taken while busy")
  `SZAD_ASSERT(a_flag, !(out_valid && flagged && distance == '0), "flag with zero distance")
  `SZAD_ASSERT(a_score, !(out_valid && distance == '0 && score != '0), "score nonzero")
  `SZAD_ASSERT(a_held, !out_valid || (samples_held != '0 &&
      samples_held <= COUNT_BITS'(WINDOW_DEPTH)), "occupancy out of range")

endmodule

bind sliding_window_zscore_anomaly_core szad_checker u_checker (.*);

[sim/sliding_window_zscore_anomaly_core_tb.sv]
// Self-checking testbench for the sliding-window z-score anomaly core.
// It predicts each result from its own copy of the window and sums.
// Depends on szad_pkg and sliding_window_zscore_anomaly_core.
`timescale 1ns / 1ps

module sliding_window_zscore_anomaly_core_tb;
  import szad_pkg::*;

  localparam logic [63:0] DIST_CAP = 64'd1 << 32;

  // One scored sample as the core reports it.
  typedef struct {
    logic        anomaly;
    logic [15:0] zdist;
    logic [15:0] score;
    logic [10:0] held;
  } verdict_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] feature_0, feature_1, feature_2, feature_3;
  logic        out_valid;
  logic        out_stall;
  logic        flagged;
  logic [15:0] distance;
  logic [15:0] score;
  logic [10:0] samples_held;
  logic        cfg_write;
  logic [15:0] cfg_data;

  sliding_window_zscore_anomaly_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .feature_0(feature_0), .feature_1(feature_1),
    .feature_2(feature_2), .feature_3(feature_3),
    .out_valid(out_valid), .out_stall(out_stall),
    .flagged(flagged), .distance(distance),
    .score(score), .samples_held(samples_held),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  // Shadow copy of the core's window: stored samples, pointer, occupancy,
  // running sums and sums of squares, and the threshold register.
  logic [15:0]     win_mem [WINDOW_DEPTH][NUM_FEATURES];
  logic [9:0]      win_ptr;
  int unsigned     win_count;
  longint unsigned feat_sum [NUM_FEATURES];
  longint unsigned feat_sq  [NUM_FEATURES];
  logic [15:0]     thresh;

  verdict_t pending_verdicts[$];
  bit       failed;
  bit       calm;      // set for the last part of the run: no idling at all
  int       stall_left;

  // Floor of the square root by setting result bits from the top down.
  function automatic logic [15:0] root_floor(input longint unsigned v);
    logic [15:0] r;
    logic [15:0] c;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      c = r | (16'd1 << b);
      if (longint'(c) * longint'(c) <= v) r = c;
    end
    return r;
  endfunction

  // Scores one sample against the window held so far, then pushes it in.
  function automatic verdict_t score_and_push(input logic [63:0] word);
    verdict_t        v;
    longint unsigned n, s, nq, ss, nx, diff, den, num, d2, term, sc;
    logic [127:0]    wide;
    logic [15:0]     x [NUM_FEATURES];
    logic [15:0]     old;
    for (int i = 0; i < NUM_FEATURES; i++) x[i] = word[16*i +: 16];
    n = win_count;
    d2 = 0;
    v.zdist = 0;
    if (n != 0) begin
      for (int i = 0; i < NUM_FEATURES; i++) begin
        s    = feat_sum[i];
        nq   = n * feat_sq[i];
        ss   = s * s;
        nx   = n * x[i];
        diff = (nx >= s) ? nx - s : s - nx;
        den  = (nq > ss) ? nq - ss : 0;
        // A feature with zero variance adds nothing to the distance.
        if (den != 0) begin
          num = diff * diff;
          if (num / den >= 65536) begin
            term = DIST_CAP;
          end else begin
            wide = {64'd0, num} << 16;
            wide = wide / den;
            term = wide[63:0];
          end
          d2 += term;
        end
      end
      v.zdist = (d2 >= DIST_CAP) ? 16'hFFFF : root_floor(d2);
    end
    // A zero threshold makes every nonzero distance saturate the score.
    if (thresh == 0) begin
      v.score = (v.zdist != 0) ? 16'hFFFF : 16'd0;
    end else begin
      sc = (longint'(v.zdist) << 8) / thresh;
      v.score = (sc > 65535) ? 16'hFFFF : sc[15:0];
    end
    v.anomaly = (v.zdist > thresh);
    // Drop the oldest sample once the window is full.
    if (win_count >= WINDOW_DEPTH) begin
      for (int i = 0; i < NUM_FEATURES; i++) begin
        old = win_mem[win_ptr][i];
        feat_sum[i] -= old;
        feat_sq[i]  -= longint'(old) * longint'(old);
      end
    end else begin
      win_count++;
    end
    for (int i = 0; i < NUM_FEATURES; i++) begin
      win_mem[win_ptr][i] = x[i];
      feat_sum[i] += x[i];
      feat_sq[i]  += longint'(x[i]) * longint'(x[i]);
    end
    win_ptr++;
    v.held = win_count[10:0];
    return v;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Sends one sample word. The valid stays high after acceptance so that
  // back-to-back words need no extra assignment; park_input lowers it.
  task automatic send_sample(input logic [63:0] word);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    feature_0 <= word[15:0];
    feature_1 <= word[31:16];
    feature_2 <= word[47:32];
    feature_3 <= word[63:48];
    do @(posedge clk); while (in_stall);
    pending_verdicts = {pending_verdicts, score_and_push(word)};
  endtask

  task automatic park_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the sender until every result is back; used before each
  // threshold write so the register changes only while the core is idle.
  task automatic drain_results();
    park_input();
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    thresh = value;
    @(posedge clk);
  endtask

  function automatic logic [63:0] four_of(input logic [15:0] a, b, c, d);
    return {d, c, b, a};
  endfunction

  // The first word meets an empty window; identical words then give every
  // feature zero variance, so a small step scores nothing, and a full-scale
  // outlier then drives the distance to saturation against the tiny spread.
  task automatic test_empty_and_flat();
    send_sample(four_of(16'd100, 16'd200, 16'd300, 16'd400));
    repeat (4) send_sample(four_of(16'd100, 16'd200, 16'd300, 16'd400));
    send_sample(four_of(16'd101, 16'd200, 16'd300, 16'd400));
    send_sample(four_of(16'd100, 16'd200, 16'd300, 16'd400));
    send_sample(four_of(16'hFFFF, 16'd200, 16'd0, 16'd400));
    send_sample(four_of(16'd0, 16'd0, 16'd0, 16'd0));
  endtask

  // Field extremes under the threshold extremes, the zero threshold among
  // them, then back to the reset value.
  task automatic test_extremes();
    logic [15:0] thr_list [4];
    thr_list = '{16'd0, 16'd1, 16'hFFFF, 16'd768};
    foreach (thr_list[t]) begin
      write_threshold(thr_list[t]);
      send_sample(four_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_sample(four_of(16'd0, 16'hFFFF, 16'd0, 16'hFFFF));
      send_sample(four_of(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
    end
  endtask

  // Mostly samples scattered around per-feature means, with some full-range
  // noise and extremes mixed in so the distances span the whole scale.
  task automatic test_random_phase(input int count, input logic [15:0] thr);
    int base [NUM_FEATURES];
    int spread;
    int val;
    logic [63:0] word;
    write_threshold(thr);
    for (int i = 0; i < NUM_FEATURES; i++) base[i] = $urandom_range(0, 65535);
    spread = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40)
                                         : $urandom_range(0, 4000);
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < NUM_FEATURES; i++) begin
        case ($urandom_range(0, 19))
          0: val = $urandom_range(0, 65535);
          1: val = ($urandom_range(0, 1) == 0) ? 0 : 65535;
          default: begin
            val = base[i] + int'($urandom_range(0, 2 * spread)) - spread;
            if (val < 0) val = 0;
            if (val > 65535) val = 65535;
          end
        endcase
        word[16*i +: 16] = val[15:0];
      end
      send_sample(word);
    end
  endtask

  // Compares every handed-over result with the oldest prediction.
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result word: dist %0d score %0d", $time,
                 distance, score);
        failed = 1;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (flagged !== exp_v.anomaly) begin
          $display("%0t: flagged expected %0d actual %0d", $time,
                   exp_v.anomaly, flagged);
          failed = 1;
        end
        if (distance !== exp_v.zdist) begin
          $display("%0t: distance expected %0d actual %0d", $time,
                   exp_v.zdist, distance);
          failed = 1;
        end
        if (score !== exp_v.score) begin
          $display("%0t: score expected %0d actual %0d", $time,
                   exp_v.score, score);
          failed = 1;
        end
        if (samples_held !== exp_v.held) begin
          $display("%0t: samples_held expected %0d actual %0d", $time,
                   exp_v.held, samples_held);
          failed = 1;
        end
      end
    end
    // Receiver stalls come in bursts; no new burst starts once the run turns calm.
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: ends a run that hangs and reports it as failed.
  initial begin
    #2000000;
    $display("sliding_window_zscore_anomaly_core_tb NOT OK");
    $finish;
  end

  initial begin
    failed     = 0;
    calm       = 0;
    stall_left = 0;
    win_ptr    = 0;
    win_count  = 0;
    thresh     = THRESHOLD_RESET;
    for (int i = 0; i < NUM_FEATURES; i++) begin
      feat_sum[i] = 0;
      feat_sq[i]  = 0;
    end
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    feature_0 <= '0;
    feature_1 <= '0;
    feature_2 <= '0;
    feature_3 <= '0;
    out_stall <= 1'b0;
    cfg_write <= 1'b0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_flat();
    test_extremes();
    // Over 1024 random words wrap the window so old samples drop out.
    test_random_phase(450, 16'd768);
    test_random_phase(450, 16'($urandom_range(1, 65535)));
    test_random_phase(400, 16'($urandom_range(128, 1024)));
    calm = 1;
    test_random_phase(430, 16'd512);

    park_input();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed && pending_verdicts.size() == 0) begin
      $display("sliding_window_zscore_anomaly_core_tb OK");
    end else begin
      $display("sliding_window_zscore_anomaly_core_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/szad_pkg.sv
rtl/szad_lane.sv
rtl/szad_merge.sv
rtl/sliding_window_zscore_anomaly_core.sv
rtl/szad_checker.sv
sim/sliding_window_zscore_anomaly_core_tb.sv
